@@ hdl/egpt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// egpt_pkg
// Shared types, field widths and codes of the epoch grace-period tracker.
// ============================================================================
package egpt_pkg;

    // Field widths of the request and response payloads.
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int EPOCH_W  = 64;

    // Default sizing of the reader table.
    localparam int MAX_SLOTS_DEF = 64;
    localparam int NEST_BITS_DEF = 8;

    // Amount the global epoch advances on every sync start.
    localparam logic [EPOCH_W-1:0] EPOCH_STEP = EPOCH_W'(2);

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_REGISTER   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UNREGISTER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOCK       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNLOCK     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SYNC_START = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SYNC_POLL  = 3'd5;

    // Response status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNREG     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NESTED    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_UNMATCHED = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd5;

    // Request payload.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
    } egpt_req_t;

    // Response payload.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   assigned_slot;
        logic [EPOCH_W-1:0]  target_epoch;
        logic                grace_done;
    } egpt_rsp_t;

endpackage : egpt_pkg
`default_nettype wire

@@ hdl/epoch_grace_period_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// epoch_grace_period_tracker
// Epoch-based grace-period tracker for a table of reader slots.
// ============================================================================
// Usage:
//   Requests enter on the s_ channel (kind, slot) and each one produces exactly
//   one response on the m_ channel (status, assigned_slot, target_epoch,
//   grace_done), in request order. Both channels use valid/ready.
//   Requests answered from the counters alone finish at acceptance; unregister,
//   lock and unlock after a memory read; a scan once it finds its answer or
//   reaches the last used entry. Each response then passes the output register.
//   Throughput: one request at a time. Lock, unlock and unregister do one memory
//   read and, on success, one write-back. Register with a free hole and
//   a poll or sync start with readers inside a section scan the slot memory one
//   entry per cycle through its single read port. Others need no memory read.
//   Reset: all slots are free at once; the table is tracked by a fill count,
//   so there is no clearing pass. Epoch and pending target return to zero.
//   Stall: the output register holds a response while m_ready is low; one more
//   request can complete behind it and waits in the sequencer until the
//   register frees.
// ============================================================================
module epoch_grace_period_tracker
    import egpt_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int NEST_BITS = NEST_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire egpt_req_t s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output egpt_rsp_t      m_data
);

    logic      rsp_valid;
    logic      rsp_ready;
    egpt_rsp_t rsp;

    // Request sequencer and slot memory.
    egpt_core #(
        .MAX_SLOTS (MAX_SLOTS),
        .NEST_BITS (NEST_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Response output register.
    egpt_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rsp_valid),
        .in_ready (rsp_ready),
        .in_data  (rsp),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule : epoch_grace_period_tracker
`default_nettype wire

@@ hdl/egpt_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// egpt_core
// Request sequencer around the reader-slot memory: read-modify-write of one
// slot for lock, unlock and unregister, and a one-entry-per-cycle scan for
// register and grace-period polling.
// ============================================================================
module egpt_core
    import egpt_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int NEST_BITS = NEST_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire egpt_req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output egpt_rsp_t      rsp
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int ENT_W = 1 + EPOCH_W + NEST_BITS;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RMW  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    // Slot memory: {registered, epoch stamp, nesting depth} per entry.
    logic [ENT_W-1:0] slot_mem [MAX_SLOTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    logic [1:0]          state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [IDX_W-1:0]    slot_idx_reg, slot_idx_next;
    logic [CNT_W-1:0]    slots_used_reg, slots_used_next;
    logic [CNT_W-1:0]    reg_count_reg, reg_count_next;
    logic [CNT_W-1:0]    active_count_reg, active_count_next;
    logic [CNT_W-1:0]    data_idx_reg, data_idx_next;
    logic [EPOCH_W-1:0]  global_epoch_reg, global_epoch_next;
    logic [EPOCH_W-1:0]  target_reg, target_next;
    egpt_rsp_t           res_reg;

    logic                 fin_valid;
    egpt_rsp_t            fin_res;
    logic                 e_reg;
    logic [EPOCH_W-1:0]   e_epoch;
    logic [NEST_BITS-1:0] e_nest;
    logic [NEST_BITS-1:0] nest_inc;
    logic [NEST_BITS-1:0] nest_dec;
    logic [CNT_W-1:0]     data_idx_plus;
    logic                 scan_last;
    logic                 poll_hit;
    logic [EPOCH_W-1:0]   epoch_adv;
    logic [EPOCH_W-1:0]   poll_target;

    // Fields of the entry read in the previous cycle.
    assign e_reg    = rd_data_reg[ENT_W-1];
    assign e_epoch  = rd_data_reg[NEST_BITS +: EPOCH_W];
    assign e_nest   = rd_data_reg[NEST_BITS-1:0];
    assign nest_inc = e_nest + NEST_BITS'(1);
    assign nest_dec = e_nest - NEST_BITS'(1);

    // Scan bookkeeping and the stale-reader test.
    assign data_idx_plus = data_idx_reg + CNT_W'(1);
    assign scan_last     = (data_idx_plus == slots_used_reg);
    assign poll_hit      = e_reg && (e_epoch != '0) && (e_epoch < target_reg);
    assign epoch_adv     = global_epoch_reg + EPOCH_STEP;
    assign poll_target   = (req.kind == KIND_SYNC_START) ? epoch_adv : target_reg;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = fin_valid;
    assign rsp       = fin_res;

    // Next-state and memory access logic.
    always_comb begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        slot_idx_next     = slot_idx_reg;
        slots_used_next   = slots_used_reg;
        reg_count_next    = reg_count_reg;
        active_count_next = active_count_reg;
        data_idx_next     = data_idx_reg;
        global_epoch_next = global_epoch_reg;
        target_next       = target_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = '0;
        fin_valid         = 1'b0;
        fin_res           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    kind_next     = req.kind;
                    slot_idx_next = IDX_W'(req.slot);
                    case (req.kind)
                        KIND_REGISTER: begin
                            if (reg_count_reg == slots_used_reg) begin
                                // No hole below the fill mark: extend the table.
                                fin_valid = 1'b1;
                                if (slots_used_reg == CNT_W'(MAX_SLOTS)) begin
                                    fin_res.status = STATUS_FULL;
                                end else begin
                                    mem_we          = 1'b1;
                                    mem_waddr       = IDX_W'(slots_used_reg);
                                    mem_wdata       = {1'b1, {EPOCH_W{1'b0}},
                                                       {NEST_BITS{1'b0}}};
                                    slots_used_next = slots_used_reg + CNT_W'(1);
                                    reg_count_next  = reg_count_reg + CNT_W'(1);
                                    fin_res.assigned_slot = SLOT_W'(slots_used_reg);
                                end
                            end else begin
                                // Search for the lowest free slot.
                                mem_re        = 1'b1;
                                mem_raddr     = '0;
                                data_idx_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        KIND_UNREGISTER, KIND_LOCK, KIND_UNLOCK: begin
                            if (32'(req.slot) < 32'(slots_used_reg)) begin
                                mem_re     = 1'b1;
                                mem_raddr  = IDX_W'(req.slot);
                                state_next = ST_RMW;
                            end else begin
                                fin_valid      = 1'b1;
                                fin_res.status = STATUS_UNREG;
                            end
                        end
                        KIND_SYNC_START, KIND_SYNC_POLL: begin
                            if (req.kind == KIND_SYNC_START) begin
                                global_epoch_next = epoch_adv;
                                target_next       = epoch_adv;
                            end
                            if (active_count_reg == '0) begin
                                // No reader inside a read section.
                                fin_valid            = 1'b1;
                                fin_res.target_epoch = poll_target;
                                fin_res.grace_done   = 1'b1;
                            end else begin
                                mem_re        = 1'b1;
                                mem_raddr     = '0;
                                data_idx_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default: begin
                            fin_valid = 1'b1;
                        end
                    endcase
                end
            end

            ST_RMW: begin
                fin_valid = 1'b1;
                mem_waddr = slot_idx_reg;
                if (!e_reg) begin
                    fin_res.status = STATUS_UNREG;
                end else begin
                    case (kind_reg)
                        KIND_UNREGISTER: begin
                            if (e_nest != '0) begin
                                fin_res.status = STATUS_NESTED;
                            end else begin
                                mem_we         = 1'b1;
                                mem_wdata      = '0;
                                reg_count_next = reg_count_reg - CNT_W'(1);
                            end
                        end
                        KIND_LOCK: begin
                            if (&e_nest) begin
                                fin_res.status = STATUS_OVERFLOW;
                            end else begin
                                mem_we = 1'b1;
                                if (e_nest == '0) begin
                                    // Outermost entry stamps the current epoch.
                                    mem_wdata = {1'b1, global_epoch_reg | EPOCH_W'(1),
                                                 nest_inc};
                                    active_count_next = active_count_reg + CNT_W'(1);
                                end else begin
                                    mem_wdata = {1'b1, e_epoch, nest_inc};
                                end
                            end
                        end
                        default: begin
                            if (e_nest == '0) begin
                                fin_res.status = STATUS_UNMATCHED;
                            end else begin
                                mem_we = 1'b1;
                                if (nest_dec == '0) begin
                                    // Leaving the outermost section clears the stamp.
                                    mem_wdata = {1'b1, {EPOCH_W{1'b0}}, nest_dec};
                                    active_count_next = active_count_reg - CNT_W'(1);
                                end else begin
                                    mem_wdata = {1'b1, e_epoch, nest_dec};
                                end
                            end
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                data_idx_next = data_idx_plus;
                if (kind_reg == KIND_REGISTER) begin
                    if (!e_reg) begin
                        fin_valid      = 1'b1;
                        mem_we         = 1'b1;
                        mem_waddr      = IDX_W'(data_idx_reg);
                        mem_wdata      = {1'b1, {EPOCH_W{1'b0}}, {NEST_BITS{1'b0}}};
                        reg_count_next = reg_count_reg + CNT_W'(1);
                        fin_res.assigned_slot = SLOT_W'(data_idx_reg);
                    end
                end else begin
                    if (poll_hit || scan_last) begin
                        fin_valid            = 1'b1;
                        fin_res.target_epoch = target_reg;
                        fin_res.grace_done   = !poll_hit;
                    end
                end
                // Keep the read port one entry ahead while the scan goes on.
                mem_re    = !fin_valid;
                mem_raddr = IDX_W'(data_idx_plus);
            end

            default: begin
                fin_valid = 1'b1;
                fin_res   = res_reg;
            end
        endcase

        // A finished response waits here if the output stage is full.
        if (fin_valid) begin
            state_next = rsp_ready ? ST_IDLE : ST_RESP;
        end
    end

    // Slot memory with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        slot_idx_reg <= slot_idx_next;
        data_idx_reg <= data_idx_next;
        if (fin_valid) begin
            res_reg <= fin_res;
        end
    end

    // Control state and epoch registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            slots_used_reg   <= '0;
            reg_count_reg    <= '0;
            active_count_reg <= '0;
            global_epoch_reg <= '0;
            target_reg       <= '0;
        end else begin
            state_reg        <= state_next;
            slots_used_reg   <= slots_used_next;
            reg_count_reg    <= reg_count_next;
            active_count_reg <= active_count_next;
            global_epoch_reg <= global_epoch_next;
            target_reg       <= target_next;
        end
    end

    // The sequencer never reads and writes the memory in the same cycle.
    a_mem_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("slot memory read and write in the same cycle");

    // The registered count never exceeds the fill mark, nor the active count the registered count.
    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (reg_count_reg <= slots_used_reg) && (active_count_reg <= reg_count_reg))
        else $error("reader counts inconsistent");

    // The fill mark never passes the table size.
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        slots_used_reg <= CNT_W'(MAX_SLOTS))
        else $error("slot fill mark beyond table size");

    // A register scan always finds its hole by the last used entry.
    a_reg_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && kind_reg == KIND_REGISTER && scan_last) |-> !e_reg)
        else $error("register scan found no free slot");

    // The global epoch advances in even steps only.
    a_epoch_even: assert property (@(posedge aclk) disable iff (!aresetn)
        !global_epoch_reg[0])
        else $error("global epoch became odd");

endmodule : egpt_core
`default_nettype wire

@@ hdl/egpt_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// egpt_out_reg
// Output register of the response channel; frees the sequencer while the
// receiver stalls.
// ============================================================================
module egpt_out_reg
    import egpt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire egpt_rsp_t in_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output egpt_rsp_t      m_data
);

    logic      m_valid_reg;
    egpt_rsp_t m_data_reg;

    // Take a new response when empty or when the held one leaves.
    assign in_ready = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    // Held response.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            m_data_reg <= in_data;
        end
    end

endmodule : egpt_out_reg
`default_nettype wire
